// ===== rtl/dlf_pkg.sv =====
// Package for the IPv4 denylist filter: sizes, codes, shared types.
// No dependencies; compiled first.
`timescale 1ns / 1ps
package dlf_pkg;

   localparam int unsigned DENY_ENTRIES = 1024;
   localparam int unsigned IDX_W        = $clog2(DENY_ENTRIES);
   localparam int unsigned CNT_W        = IDX_W + 1;
   localparam int unsigned ENTRY_W      = 33;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam cnt_type DENY_DEPTH = cnt_type'(DENY_ENTRIES);

   typedef enum logic [1:0] {
      OP_FRAME  = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [1:0] STAT_DONE   = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_ABSENT = 2'd2;

   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [15:0] POS_IP_LAST    = 16'd33;  // len >= 34
   localparam logic [15:0] POS_TCP_LAST   = 16'd53;  // len >= 54

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // frame header fields including the byte being accepted
   typedef struct packed {
      logic        ip_ok;
      logic        tcp_ok;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] source_port;
      logic [15:0] dst_port;
   } frame_info_type;

endpackage

// ===== rtl/dlf_if.sv =====
// Valid/ready channel interfaces for request and response items.
// Depends on nothing.
`timescale 1ns / 1ps
interface dlf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [31:0] deny_addr;
   modport source(output valid, operation, data_byte, last_byte, deny_addr, input ready);
   modport sink(input valid, operation, data_byte, last_byte, deny_addr, output ready);
endinterface

interface dlf_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic        verdict;
   logic        event_valid;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] source_port;
   logic [15:0] dst_port;
   logic [1:0]  table_status;
   modport source(output valid, result_kind, verdict, event_valid, src_addr, dst_addr,
                  source_port, dst_port, table_status, input ready);
   modport sink(input valid, result_kind, verdict, event_valid, src_addr, dst_addr,
                source_port, dst_port, table_status, output ready);
endinterface

// ===== rtl/dlf_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module dlf_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/dlf_parser.sv =====
// Frame byte parser: byte counter and header field capture.
// Depends on dlf_pkg.
`timescale 1ns / 1ps
module dlf_parser import dlf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_en,
   input  logic [7:0]     data_byte,
   input  logic           last_byte,
   output frame_info_type info
);
   logic [15:0] pos_ff, pos_in;
   logic [15:0] ether_ff, ether_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in, dst_ff, dst_in;
   logic [15:0] sport_ff, sport_in, dport_ff, dport_in;

   // fields as they stand after the current byte
   always_comb begin
      ether_in = ether_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;
      if (pos_ff == 16'd12 || pos_ff == 16'd13) begin
         ether_in = {ether_ff[7:0], data_byte};
      end else if (pos_ff == 16'd23) begin
         proto_in = data_byte;
      end else if (pos_ff >= 16'd26 && pos_ff <= 16'd29) begin
         src_in = {src_ff[23:0], data_byte};
      end else if (pos_ff >= 16'd30 && pos_ff <= 16'd33) begin
         dst_in = {dst_ff[23:0], data_byte};
      end else if (pos_ff == 16'd34 || pos_ff == 16'd35) begin
         sport_in = {sport_ff[7:0], data_byte};
      end else if (pos_ff == 16'd36 || pos_ff == 16'd37) begin
         dport_in = {dport_ff[7:0], data_byte};
      end
      pos_in = (pos_ff == 16'hFFFF) ? pos_ff : pos_ff + 16'd1;
   end

   assign info.ip_ok       = (ether_in == ETHERTYPE_IPV4) && (pos_ff >= POS_IP_LAST);
   assign info.tcp_ok      = (proto_in == PROTO_TCP) && (pos_ff >= POS_TCP_LAST);
   assign info.src_addr    = src_in;
   assign info.dst_addr    = dst_in;
   assign info.source_port = sport_in;
   assign info.dst_port    = dport_in;

   always_ff @(posedge clock) begin
      if (reset || (byte_en && last_byte)) begin
         pos_ff   <= '0;
         ether_ff <= '0;
         proto_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         sport_ff <= '0;
         dport_ff <= '0;
      end else if (byte_en) begin
         pos_ff   <= pos_in;
         ether_ff <= ether_in;
         proto_ff <= proto_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
      end
   end
endmodule

// ===== rtl/dlf_ctrl.sv =====
// Table controller: scans the deny RAM, edits it and forms response items.
// Depends on dlf_pkg, dlf_if and dlf_ram.
`timescale 1ns / 1ps
module dlf_ctrl import dlf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  op_type         op,
   input  logic [31:0]    deny_addr,
   input  frame_info_type info,
   output logic           idle,
   dlf_rsp_if.source      rsp_if
);
   state_type state_ff, state_in;

   op_type         op_ff;
   logic [31:0]    key_ff;
   frame_info_type info_ff;
   cnt_type        hwm_ff, issue_ff;
   logic           rdv_ff;
   idx_type        chk_idx_ff;
   logic           hit_ff, free_found_ff;
   idx_type        hit_idx_ff, free_idx_ff;

   logic              rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic              match, free_seen, scan_end;
   logic              rsp_load;
   logic              wr_en;
   idx_type           wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic              grow;

   logic        rsp_valid_ff, kind_ff, verdict_ff, event_ff;
   logic [31:0] rsrc_ff, rdst_ff;
   logic [15:0] rsport_ff, rdport_ff;
   logic [1:0]  status_ff;
   logic        kind_in, verdict_in, event_in;
   logic [1:0]  status_in;

   dlf_ram #(.DEPTH(DENY_ENTRIES), .WIDTH(ENTRY_W)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(issue_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   assign idle      = (state_ff == ST_IDLE);
   assign rd_en     = (state_ff == ST_SCAN) && (issue_ff != hwm_ff);
   assign match     = rdv_ff && rd_data[ENTRY_W-1] && (rd_data[31:0] == key_ff);
   assign free_seen = rdv_ff && !rd_data[ENTRY_W-1];
   assign scan_end  = match || (!rdv_ff && !rd_en);
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (op == OP_FRAME && !info.ip_ok) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the finish step: response fields and table write
   always_comb begin
      kind_in    = KIND_STATUS;
      verdict_in = 1'b0;
      event_in   = 1'b0;
      status_in  = STAT_DONE;
      wr_en      = 1'b0;
      wr_addr    = hit_idx_ff;
      wr_data    = {1'b0, key_ff};
      grow       = 1'b0;
      unique case (op_ff)
         OP_FRAME: begin
            kind_in    = KIND_VERDICT;
            verdict_in = info_ff.ip_ok && hit_ff;
            event_in   = info_ff.ip_ok && !hit_ff && info_ff.tcp_ok;
         end
         OP_ADD: begin
            wr_data = {1'b1, key_ff};
            if (!hit_ff) begin
               if (free_found_ff) begin
                  wr_en   = rsp_load;
                  wr_addr = free_idx_ff;
               end else if (hwm_ff != DENY_DEPTH) begin
                  wr_en   = rsp_load;
                  wr_addr = hwm_ff[IDX_W-1:0];
                  grow    = rsp_load;
               end else begin
                  status_in = STAT_FULL;
               end
            end
         end
         OP_REMOVE: begin
            if (hit_ff) begin
               wr_en = rsp_load;
            end else begin
               status_in = STAT_ABSENT;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hwm_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= rd_en;
         if (grow) begin
            hwm_ff <= hwm_ff + cnt_type'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (idle && start) begin
         op_ff         <= op;
         key_ff        <= (op == OP_FRAME) ? info.src_addr : deny_addr;
         info_ff       <= info;
         issue_ff      <= '0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         if (rd_en) begin
            issue_ff <= issue_ff + cnt_type'(1);
         end
         if (match) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= chk_idx_ff;
         end
         if (free_seen && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= chk_idx_ff;
         end
      end
      chk_idx_ff <= issue_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         kind_ff    <= kind_in;
         verdict_ff <= verdict_in;
         event_ff   <= event_in;
         status_ff  <= status_in;
         rsrc_ff    <= event_in ? info_ff.src_addr : '0;
         rdst_ff    <= event_in ? info_ff.dst_addr : '0;
         rsport_ff  <= event_in ? info_ff.source_port : '0;
         rdport_ff  <= event_in ? info_ff.dst_port : '0;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_kind  = kind_ff;
   assign rsp_if.verdict      = verdict_ff;
   assign rsp_if.event_valid  = event_ff;
   assign rsp_if.src_addr     = rsrc_ff;
   assign rsp_if.dst_addr     = rdst_ff;
   assign rsp_if.source_port  = rsport_ff;
   assign rsp_if.dst_port     = rdport_ff;
   assign rsp_if.table_status = status_ff;

   a_write_in_finish: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_FINISH && rsp_load))
      else $error("table write outside finish step");
   a_hwm_bound: assert property (@(posedge clock) disable iff (reset)
      hwm_ff <= DENY_DEPTH)
      else $error("high-water mark beyond table depth");
   a_match_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && match) |=> (state_ff == ST_FINISH && hit_ff))
      else $error("hit did not end the scan");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_if.valid)
      else $error("response item lost");
endmodule

// ===== rtl/ipv4_denylist_packet_filter.sv =====
// Top level of the IPv4 source address denylist filter.
// Depends on dlf_pkg, dlf_if, dlf_parser, dlf_ctrl (with dlf_ram).
//
//   channel  | dir | handshake        | payload
//   req_if   | in  | valid/ready      | operation, data_byte, last_byte, deny_addr
//   rsp_if   | out | valid/ready      | result_kind, verdict, event_valid, addrs,
//            |     |                  | ports, table_status
//
// Frame bytes other than the last are taken one per cycle with no result.
// A last byte or a table add/remove scans the deny RAM one entry per cycle
// up to its high-water mark H (highest slot ever used plus one), and stops
// early when the address hits; the last byte of a non-IPv4 or short frame
// skips the scan and goes straight to the finish step.
// Slots at or above H are never read, so reset needs no clearing pass.
// While a scan runs the request side is held; a response item still waiting
// holds the controller in its finish step, and with it the whole request side.
`timescale 1ns / 1ps
module ipv4_denylist_packet_filter import dlf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dlf_req_if.sink   req_if,
   dlf_rsp_if.source rsp_if
);
   frame_info_type info;
   logic           idle;
   logic           accept;
   op_type         op;

   assign op            = op_type'(req_if.operation);
   assign req_if.ready  = idle;
   assign accept        = req_if.valid && idle;

   // only the frame-ending byte and table edits need the controller
   logic start;
   always_comb begin
      unique case (op) inside
         OP_FRAME:             start = accept && req_if.last_byte;
         OP_ADD, OP_REMOVE:    start = accept;
         default:              start = 1'b0;
      endcase
   end

   dlf_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .byte_en  (accept && op == OP_FRAME),
      .data_byte(req_if.data_byte),
      .last_byte(req_if.last_byte),
      .info     (info)
   );

   dlf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (op),
      .deny_addr(req_if.deny_addr),
      .info     (info),
      .idle     (idle),
      .rsp_if   (rsp_if)
   );
endmodule

// ===== verif/ipv4_denylist_packet_filter_test.sv =====
// Testbench for ipv4_denylist_packet_filter: directed and random frames and table edits,
// checked against an in-bench predictor. Depends on dlf_pkg, dlf_if and the RTL top.
`timescale 1ns / 1ps
module ipv4_denylist_packet_filter_test import dlf_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 1200;   // longer than a full-table scan
   localparam int POOL_SIZE      = 8;

   // one result item as the block presents it
   typedef struct packed {
      logic        kind;
      logic        verdict;
      logic        ev;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  status;
   } filter_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dlf_req_if req_if ();
   dlf_rsp_if rsp_if ();

   ipv4_denylist_packet_filter u_top (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor state: frame parser and deny table
   // ---------------------------------------------------------------------
   logic [15:0] frame_pos;
   logic [15:0] frame_etype;
   logic [7:0]  frame_proto;
   logic [31:0] frame_src, frame_dst;
   logic [15:0] frame_sport, frame_dport;
   logic        deny_valid [DENY_ENTRIES];
   logic [31:0] deny_addr_q [DENY_ENTRIES];

   filter_result_type expected_results [$];
   logic [7:0]        frame_buf [$];
   logic [31:0]       addr_pool [POOL_SIZE];

   int fail_count;
   int items_sent;
   int results_seen;
   int drops_seen;
   int events_seen;
   int burst_left;
   int idle_cycles;
   bit hold_request;

   function automatic int deny_lookup(input logic [31:0] a);
      for (int i = 0; i < DENY_ENTRIES; i++)
         if (deny_valid[i] && deny_addr_q[i] == a) return i;
      return -1;
   endfunction

   function automatic void clear_frame_state();
      frame_pos   = '0;
      frame_etype = '0;
      frame_proto = '0;
      frame_src   = '0;
      frame_dst   = '0;
      frame_sport = '0;
      frame_dport = '0;
   endfunction

   // Apply one accepted item to the predictor; queue the result it causes.
   function automatic void predict_filter(input op_type op, input logic [7:0] b,
                                          input logic last, input logic [31:0] a);
      filter_result_type r;
      int hit;
      int free_slot;
      int len;
      r = '0;
      if (op == OP_ADD || op == OP_REMOVE) begin
         hit = deny_lookup(a);
         r.kind = KIND_STATUS;
         r.status = STAT_DONE;
         if (op == OP_ADD) begin
            if (hit < 0) begin
               free_slot = -1;
               for (int i = 0; i < DENY_ENTRIES; i++)
                  if (!deny_valid[i]) begin
                     free_slot = i;
                     break;
                  end
               if (free_slot < 0) r.status = STAT_FULL;
               else begin
                  deny_valid[free_slot]  = 1'b1;
                  deny_addr_q[free_slot] = a;
               end
            end
         end else if (hit < 0) r.status = STAT_ABSENT;
         else deny_valid[hit] = 1'b0;
         expected_results.push_back(r);
         return;
      end
      if (op != OP_FRAME) return;
      // header capture by position, fixed 20-byte IP header
      case (frame_pos) inside
         16'd12, 16'd13: frame_etype = {frame_etype[7:0], b};
         16'd23:         frame_proto = b;
         [16'd26:16'd29]: frame_src = {frame_src[23:0], b};
         [16'd30:16'd33]: frame_dst = {frame_dst[23:0], b};
         16'd34, 16'd35: frame_sport = {frame_sport[7:0], b};
         16'd36, 16'd37: frame_dport = {frame_dport[7:0], b};
         default: ;
      endcase
      if (!last) begin
         if (frame_pos != 16'hFFFF) frame_pos++;
         return;
      end
      len = int'(frame_pos) + 1;
      r.kind = KIND_VERDICT;
      if (len >= 34 && frame_etype == ETHERTYPE_IPV4) begin
         if (deny_lookup(frame_src) >= 0) r.verdict = 1'b1;
         else if (frame_proto == PROTO_TCP && len >= 54) begin
            r.ev    = 1'b1;
            r.src   = frame_src;
            r.dst   = frame_dst;
            r.sport = frame_sport;
            r.dport = frame_dport;
         end
      end
      clear_frame_state();
      expected_results.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // request side: bursts with random gaps, driven at the falling edge
   // ---------------------------------------------------------------------
   task automatic send_item(input op_type op, input logic [7:0] b, input logic last,
                            input logic [31:0] a);
      if (burst_left <= 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 20);
      end
      req_if.valid     = 1'b1;
      req_if.operation = op;
      req_if.data_byte = b;
      req_if.last_byte = last;
      req_if.deny_addr = a;
      do @(posedge clock); while (!req_if.ready);
      predict_filter(op, b, last, a);
      items_sent++;
      @(negedge clock);
      burst_left--;
   endtask

   // table edit; the byte and last fields are don't-care and get noise
   task automatic send_table_op(input op_type op, input logic [31:0] a);
      send_item(op, 8'($urandom), 1'($urandom), a);
   endtask

   // send frame_buf as one frame; deny_addr is ignored and gets noise
   task automatic send_frame();
      int n;
      n = frame_buf.size();
      for (int i = 0; i < n; i++)
         send_item(OP_FRAME, frame_buf[i], (i == n - 1), $urandom);
   endtask

   // fill frame_buf with a frame of the given length and header fields
   task automatic build_frame(input int len, input logic [15:0] etype,
                              input logic [7:0] proto, input logic [31:0] src,
                              input logic [31:0] dst, input logic [15:0] sport,
                              input logic [15:0] dport);
      logic [7:0] b;
      frame_buf.delete();
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         case (i)
            12: b = etype[15:8];
            13: b = etype[7:0];
            23: b = proto;
            26: b = src[31:24];
            27: b = src[23:16];
            28: b = src[15:8];
            29: b = src[7:0];
            30: b = dst[31:24];
            31: b = dst[23:16];
            32: b = dst[15:8];
            33: b = dst[7:0];
            34: b = sport[15:8];
            35: b = sport[7:0];
            36: b = dport[15:8];
            37: b = dport[7:0];
            default: ;
         endcase
         frame_buf.push_back(b);
      end
   endtask

   // ---------------------------------------------------------------------
   // response side: random stall pattern plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int hold_left;
      int mode_left;
      int stall_pct;
      hold_left = 0;
      mode_left = 0;
      stall_pct = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = 500;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 150);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 1'b0;
         end else rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // checker: oldest expectation against each accepted result item
   always @(posedge clock) begin
      filter_result_type got, exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.result_kind, rsp_if.verdict, rsp_if.event_valid, rsp_if.src_addr,
                 rsp_if.dst_addr, rsp_if.source_port, rsp_if.dst_port,
                 rsp_if.table_status};
         results_seen++;
         if (got.kind == KIND_VERDICT && got.verdict) drops_seen++;
         if (got.ev) events_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result item kind=%0d verdict=%0d ev=%0d", $time,
                     got.kind, got.verdict, got.ev);
            fail_count++;
         end else begin
            exp = expected_results.pop_front();
            if (got.kind !== exp.kind || got.verdict !== exp.verdict ||
                got.ev !== exp.ev || got.src !== exp.src || got.dst !== exp.dst ||
                got.sport !== exp.sport || got.dport !== exp.dport ||
                got.status !== exp.status) begin
               $display({"%0t: mismatch exp kind=%0d verdict=%0d ev=%0d src=%h dst=%h",
                         " sp=%h dp=%h st=%0d"},
                        $time, exp.kind, exp.verdict, exp.ev, exp.src, exp.dst,
                        exp.sport, exp.dport, exp.status);
               $display({"%0t:          got kind=%0d verdict=%0d ev=%0d src=%h dst=%h",
                         " sp=%h dp=%h st=%0d"},
                        $time, got.kind, got.verdict, got.ev, got.src, got.dst,
                        got.sport, got.dport, got.status);
               fail_count++;
            end
         end
      end
   end

   // watchdog: cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time,
                  expected_results.size());
         $display("** ipv4_denylist_packet_filter: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // add, duplicate add, remove, absent remove, unused code, address extremes
   task automatic test_table_edits();
      send_table_op(OP_ADD, 32'h0000_0000);
      send_table_op(OP_ADD, 32'hFFFF_FFFF);
      send_table_op(OP_ADD, 32'hFFFF_FFFF);       // already present: done
      send_table_op(OP_REMOVE, 32'h1234_5678);    // never added: absent
      send_table_op(OP_REMOVE, 32'h0000_0000);
      send_table_op(OP_REMOVE, 32'h0000_0000);    // now absent
      send_item(OP_NONE, 8'hFF, 1'b1, 32'hFFFF_FFFF); // ignored, no result
   endtask

   // each verdict path, the length thresholds and a mid-frame table edit
   task automatic test_frame_verdicts();
      build_frame(1, 16'h0800, PROTO_TCP, 32'd0, 32'd0, 16'd0, 16'd0); send_frame();
      build_frame(13, 16'h0800, PROTO_TCP, 32'd0, 32'd0, 16'd0, 16'd0); send_frame();
      build_frame(60, 16'h86DD, PROTO_TCP, 32'hFFFF_FFFF, 32'd1, 16'd2, 16'd3);
      send_frame();
      build_frame(33, 16'h0800, PROTO_TCP, 32'hFFFF_FFFF, 32'd1, 16'd2, 16'd3);
      send_frame();
      build_frame(34, 16'h0800, PROTO_TCP, 32'hFFFF_FFFF, 32'd1, 16'd2, 16'd3);
      send_frame();  // drop
      build_frame(34, 16'h0800, 8'd17, 32'h0A00_0001, 32'd1, 16'd2, 16'd3); send_frame();
      build_frame(53, 16'h0800, PROTO_TCP, 32'h0A00_0001, 32'd1, 16'd2, 16'd3);
      send_frame();
      build_frame(54, 16'h0800, PROTO_TCP, 32'h0000_0000, 32'hFFFF_FFFF,
                  16'hFFFF, 16'h0000); send_frame();
      build_frame(64, 16'h0800, PROTO_TCP, 32'hFFFF_FFFF, 32'h0000_0000,
                  16'h0000, 16'hFFFF); send_frame();  // denied source
      // edit in the middle of a frame takes effect before its last byte
      build_frame(54, 16'h0800, PROTO_TCP, 32'hC0A8_0101, 32'h0A0A_0A0A, 16'd80, 16'd443);
      for (int i = 0; i < 40; i++) send_item(OP_FRAME, frame_buf[i], 1'b0, $urandom);
      send_table_op(OP_ADD, 32'hC0A8_0101);
      for (int i = 40; i < 54; i++) send_item(OP_FRAME, frame_buf[i], (i == 53), $urandom);
      send_table_op(OP_REMOVE, 32'hC0A8_0101);
   endtask

   // frame well past the TCP header; the counter must clear for the next one
   task automatic test_long_frame();
      build_frame(100, 16'h0800, PROTO_TCP, 32'h0102_0304, 32'h0506_0708,
                  16'h1234, 16'h5678);
      send_frame();
      build_frame(54, 16'h0800, PROTO_TCP, 32'h0A0B_0C0D, 32'h0E0F_1011, 16'd7, 16'd9);
      send_frame();
   endtask

   // mostly well-formed TCP/IPv4 frames with pool sources, table churn and noise
   task automatic test_random_traffic(input int n_items);
      int start;
      int pick;
      int len;
      logic [15:0] et;
      logic [7:0]  pr;
      logic [31:0] src;
      start = items_sent;
      for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
      while (items_sent - start < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_table_op(($urandom_range(0, 1) != 0) ? OP_ADD : OP_REMOVE,
                          ($urandom_range(0, 4) == 0) ? $urandom
                                                      : addr_pool[$urandom_range(0, POOL_SIZE - 1)]);
         end else if (pick < 28) begin
            send_item(OP_NONE, 8'($urandom), 1'($urandom), $urandom);
         end else begin
            et  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
            pr  = ($urandom_range(0, 5) == 0) ? 8'($urandom) : PROTO_TCP;
            src = ($urandom_range(0, 3) == 0) ? $urandom
                                              : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            case ($urandom_range(0, 9))
               0:       len = $urandom_range(1, 33);
               1:       len = $urandom_range(34, 53);
               default: len = $urandom_range(54, 72);
            endcase
            build_frame(len, et, pr, src, $urandom, 16'($urandom), 16'($urandom));
            send_frame();
         end
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 4; i++) begin
         send_table_op(OP_ADD, addr_pool[i % POOL_SIZE]);
         build_frame(14, 16'h0800, PROTO_TCP, 32'd0, 32'd0, 16'd0, 16'd0);
         send_frame();
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int wait_cnt;
      fail_count   = 0;
      items_sent   = 0;
      results_seen = 0;
      drops_seen   = 0;
      events_seen  = 0;
      burst_left   = 0;
      idle_cycles  = 0;
      hold_request = 1'b0;
      req_if.valid     = 1'b0;
      req_if.operation = OP_FRAME;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      req_if.deny_addr = '0;
      for (int i = 0; i < DENY_ENTRIES; i++) begin
         deny_valid[i]  = 1'b0;
         deny_addr_q[i] = '0;
      end
      clear_frame_state();

      // reset held from time zero, released at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_table_edits();
      test_frame_verdicts();
      test_long_frame();
      test_random_traffic(330);
      test_backpressure();

      req_if.valid = 1'b0;
      wait_cnt = 0;
      while (expected_results.size() != 0 && wait_cnt < WATCHDOG_LIMIT) begin
         @(negedge clock);
         wait_cnt++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  expected_results.size());
         fail_count++;
      end

      $display("Run covered %0d request items and %0d result items (%0d drops, %0d TCP events),",
               items_sent, results_seen, drops_seen, events_seen);
      $display("including length thresholds, a table edit inside a frame and a long receiver hold-off.");
      if (fail_count == 0) $display("** ipv4_denylist_packet_filter: PASSED **");
      else $display("** ipv4_denylist_packet_filter: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dlf_pkg.sv
rtl/dlf_if.sv
rtl/dlf_ram.sv
rtl/dlf_parser.sv
rtl/dlf_ctrl.sv
rtl/ipv4_denylist_packet_filter.sv
verif/ipv4_denylist_packet_filter_test.sv
